@@ src/swg_pkg.sv @@
// shared types, constants and helpers for the sine wave generator
// no dependencies
`default_nettype none

package swg_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SINE_BITS_DEF  = 16;

  // unsigned q30 constants
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [30:0] PIH_Q30 = 31'd1686629713;

  // taylor series through x^11 evaluated by horner's rule
  localparam int HORNER_CELLS = 5;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FREQUENCY   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TURNS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_TIME  = 3'd4;

  localparam logic [31:0] AMPLITUDE_RST  = 32'd655360;
  localparam logic [31:0] FREQUENCY_RST  = 32'd327680;
  localparam logic [15:0] PHASE_RST      = 16'd0;
  localparam logic [31:0] OFFSET_RST     = 32'd0;
  localparam logic [47:0] START_TIME_RST = 48'd0;

  // one sample on its way through the sine pipeline
  typedef struct packed {
    logic        active;
    logic [1:0]  quad;
    logic [30:0] x;     // angle within quadrant, radians q30
    logic [31:0] x2;    // x squared, q30
    logic [30:0] t;     // running horner term, q30
  } swg_item_t;

  // divisor of each horner step, innermost first
  function automatic int horner_divisor(input int idx);
    int d;
    case (idx)
      0:       d = 110;
      1:       d = 72;
      2:       d = 42;
      3:       d = 20;
      default: d = 6;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/swg_phase.sv @@
// phase front end: elapsed time, turn fraction, quadrant folding and x squared
// depends on swg_pkg
`default_nettype none

module swg_phase import swg_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [47:0] time_now,
  input  wire logic [47:0] start_at,
  input  wire logic [31:0] frequency,
  input  wire logic [15:0] phase_turns,
  output logic             out_valid,
  input  wire logic        out_ready,
  output swg_item_t        out_item
);

  localparam int QSH = 32 - ANGLE_BITS;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [31:0]            e_r;
  logic                   act1_r, act2_r, act3_r;
  logic [ANGLE_BITS-1:0]  ang_r;
  logic [30:0]            x3_r;
  logic [1:0]             quad3_r;
  swg_item_t              item_r;

  logic [31:0]            e_nxt;
  logic                   act_nxt;
  logic [ANGLE_BITS-1:0]  ang_nxt;
  logic [30:0]            x_nxt;
  logic [31:0]            x2_nxt;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign out_valid = v4_r;
  assign out_item  = item_r;

  // elapsed time; only the low 32 bits matter for the turn fraction
  always_comb begin
    logic [48:0] diff;
    diff    = {1'b0, time_now} - {1'b0, start_at};
    act_nxt = !diff[48];
    e_nxt   = diff[31:0];
  end

  // fractional turns plus phase
  always_comb begin
    logic [63:0] fprod;
    logic [31:0] frac;
    fprod   = 64'(frequency) * 64'(e_r);
    frac    = fprod[31:0] + {phase_turns, 16'h0000};
    ang_nxt = frac[31 -: ANGLE_BITS];
  end

  // fold into the first quadrant and scale to radians
  always_comb begin
    logic [1:0]  quad;
    logic [30:0] q;
    logic [30:0] r;
    logic [61:0] xp;
    quad  = ang_r[ANGLE_BITS-1 -: 2];
    q     = 31'(ang_r[ANGLE_BITS-3:0]) << QSH;
    r     = quad[0] ? (ONE_Q30 - q) : q;
    xp    = 62'(r) * 62'(PIH_Q30);
    x_nxt = xp[60:30];
  end

  always_comb begin
    logic [61:0] sq;
    sq     = 62'(x3_r) * 62'(x3_r);
    x2_nxt = sq[61:30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      e_r    <= e_nxt;
      act1_r <= act_nxt;
    end
    if (rdy2) begin
      ang_r  <= ang_nxt;
      act2_r <= act1_r;
    end
    if (rdy3) begin
      x3_r    <= x_nxt;
      quad3_r <= ang_r[ANGLE_BITS-1 -: 2];
      act3_r  <= act2_r;
    end
    if (rdy4) begin
      item_r.active <= act3_r;
      item_r.quad   <= quad3_r;
      item_r.x      <= x3_r;
      item_r.x2     <= x2_nxt;
      item_r.t      <= ONE_Q30;
    end
  end

endmodule

`default_nettype wire

@@ src/swg_horner_cell.sv @@
// one horner step of the sine series: t = 1 - x2 * t / divisor
// depends on swg_pkg
`default_nettype none

module swg_horner_cell import swg_pkg::*; #(
  parameter int DIVISOR = 6
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire swg_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output swg_item_t      out_item
);

  // floor(2^32 / divisor): quotient estimate is low by at most one
  localparam logic [63:0] RECIP_WIDE = (64'd1 << 32) / DIVISOR;
  localparam logic [31:0] RECIP      = RECIP_WIDE[31:0];
  localparam logic [7:0]  DIV_K      = 8'(DIVISOR);

  logic va_r, vb_r, vc_r;
  logic rdya, rdyb, rdyc;

  swg_item_t   item_a_r, item_b_r, item_c_r;
  logic [31:0] n_a_r, n_b_r, qe_b_r;

  logic [31:0] n_nxt, qe_nxt;
  logic [30:0] t_nxt;
  swg_item_t   item_c_nxt;

  assign rdyc     = !vc_r || out_ready;
  assign rdyb     = !vb_r || rdyc;
  assign rdya     = !va_r || rdyb;
  assign in_ready = rdya;

  assign out_valid = vc_r;
  assign out_item  = item_c_r;

  always_comb begin
    logic [63:0] prod;
    prod  = 64'(in_item.x2) * 64'(in_item.t);
    n_nxt = prod[61:30];
  end

  always_comb begin
    logic [63:0] prod;
    prod   = 64'(n_a_r) * 64'(RECIP);
    qe_nxt = prod[63:32];
  end

  // one correction step on the quotient estimate
  always_comb begin
    logic [39:0] rem;
    logic [31:0] q;
    rem   = 40'(n_b_r) - 40'(qe_b_r) * 40'(DIV_K);
    q     = qe_b_r + 32'(rem >= 40'(DIV_K));
    t_nxt = ONE_Q30 - q[30:0];
  end

  // pass the sample on with the new running term
  always_comb begin
    item_c_nxt   = item_b_r;
    item_c_nxt.t = t_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (rdya) va_r <= in_valid;
      if (rdyb) vb_r <= va_r;
      if (rdyc) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdya) begin
      item_a_r <= in_item;
      n_a_r    <= n_nxt;
    end
    if (rdyb) begin
      item_b_r <= item_a_r;
      n_b_r    <= n_a_r;
      qe_b_r   <= qe_nxt;
    end
    if (rdyc) begin
      item_c_r <= item_c_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/swg_scale.sv @@
// back end: final sine product, quantization, amplitude scaling, offset and saturation
// depends on swg_pkg; holds the output register
`default_nettype none

module swg_scale import swg_pkg::*; #(
  parameter int SINE_BITS = SINE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire swg_item_t   in_item,
  input  wire logic [31:0] amplitude,
  input  wire logic [31:0] offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      wave_value,
  output logic             active
);

  localparam int          PW      = 32 + SINE_BITS;
  localparam logic [63:0] FULL    = (64'd1 << (SINE_BITS - 1)) - 64'd1;
  localparam logic [63:0] HALF_Q  = 64'd1 << 29;
  localparam logic [PW-1:0] HALF_P = PW'(1) << (SINE_BITS - 2);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  logic [30:0]          s_r;
  logic [1:0]           quad1_r;
  logic                 act1_r, act2_r, act3_r, act4_r;
  logic [SINE_BITS-1:0] sv_r;
  logic [PW-1:0]        p_r;
  logic [32:0]          term_r;
  logic [31:0]          wave_r;
  logic                 act5_r;

  logic [30:0]          s_nxt;
  logic [SINE_BITS-1:0] sv_nxt;
  logic [PW-1:0]        p_nxt;
  logic [32:0]          term_nxt;
  logic [31:0]          wave_nxt;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign out_valid  = v5_r;
  assign wave_value = wave_r;
  assign active     = act5_r;

  // sin(x) = x * t, clamped to one
  always_comb begin
    logic [63:0] prod;
    prod  = 64'(in_item.x) * 64'(in_item.t);
    s_nxt = (prod[61:30] > 32'(ONE_Q30)) ? ONE_Q30 : prod[60:30];
  end

  // round to the sine width and apply the quadrant sign
  always_comb begin
    logic [63:0]          mprod;
    logic [SINE_BITS-1:0] m;
    mprod  = 64'(s_r) * FULL + HALF_Q;
    m      = {1'b0, mprod[SINE_BITS+28:30]};
    sv_nxt = quad1_r[1] ? (~m + 1'b1) : m;
  end

  always_comb begin
    p_nxt = PW'($signed({{SINE_BITS{amplitude[31]}}, amplitude})
                * $signed({{32{sv_r[SINE_BITS-1]}}, sv_r}));
  end

  // rounding half away from zero; an inactive sample gives a zero term
  always_comb begin
    logic [PW-1:0] mag;
    logic [PW-1:0] rnd;
    logic [32:0]   tmag;
    mag  = p_r[PW-1] ? (~p_r + 1'b1) : p_r;
    rnd  = (mag + HALF_P) >> (SINE_BITS - 1);
    tmag = rnd[32:0];
    if (!act3_r) begin
      term_nxt = 33'd0;
    end else if (p_r[PW-1]) begin
      term_nxt = ~tmag + 1'b1;
    end else begin
      term_nxt = tmag;
    end
  end

  always_comb begin
    logic [33:0] sum;
    sum = {{2{offset[31]}}, offset} + {term_r[32], term_r};
    if (!sum[33] && (sum[32:31] != 2'b00)) begin
      wave_nxt = 32'h7FFF_FFFF;
    end else if (sum[33] && (sum[32:31] != 2'b11)) begin
      wave_nxt = 32'h8000_0000;
    end else begin
      wave_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s_r     <= s_nxt;
      quad1_r <= in_item.quad;
      act1_r  <= in_item.active;
    end
    if (rdy2) begin
      sv_r   <= sv_nxt;
      act2_r <= act1_r;
    end
    if (rdy3) begin
      p_r    <= p_nxt;
      act3_r <= act2_r;
    end
    if (rdy4) begin
      term_r <= term_nxt;
      act4_r <= act3_r;
    end
    if (rdy5) begin
      wave_r <= wave_nxt;
      act5_r <= act4_r;
    end
  end

endmodule

`default_nettype wire

@@ src/sine_wave_generator_unit.sv @@
// sine_wave_generator_unit: top level, config registers, phase front end,
// a row of five horner cells and the scaling back end (uses swg_pkg and all swg modules)
// pipeline: 4 phase, 15 horner and 5 scaling stages from input transfer to result
// throughput: one item per cycle unless out_stall holds; every stage is a register with its own valid,
// so bubbles close up and a waiting result blocks new input only once every stage is full
// reset: synchronous active-low rst_n empties the pipeline and loads register defaults
`default_nettype none

module sine_wave_generator_unit import swg_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int SINE_BITS  = SINE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [47:0]            in_time_now,
  // result channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [31:0]          out_wave_value,
  output logic                        out_active,
  // configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [31:0] amplitude_r;
  logic [31:0] frequency_r;
  logic [15:0] phase_turns_r;
  logic [31:0] offset_r;
  logic [47:0] start_at_r;

  // handshake between the pipeline sections
  logic                       front_ready;
  logic [HORNER_CELLS:0]      chain_valid;
  logic [HORNER_CELLS:0]      chain_ready;
  swg_item_t                  chain_item [0:HORNER_CELLS];

  logic [31:0] wave_value;

  // writes are always taken; unknown indexes fall through without effect
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r   <= AMPLITUDE_RST;
      frequency_r   <= FREQUENCY_RST;
      phase_turns_r <= PHASE_RST;
      offset_r      <= OFFSET_RST;
      start_at_r    <= START_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AMPLITUDE:   amplitude_r   <= cfg_data[31:0];
        REG_FREQUENCY:   frequency_r   <= cfg_data[31:0];
        REG_PHASE_TURNS: phase_turns_r <= cfg_data[15:0];
        REG_OFFSET:      offset_r      <= cfg_data[31:0];
        REG_START_TIME:  start_at_r    <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  assign in_stall = !front_ready;

  // front end: elapsed time -> turn fraction -> folded angle x and x squared
  swg_phase #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (front_ready),
    .time_now    (in_time_now),
    .start_at    (start_at_r),
    .frequency   (frequency_r),
    .phase_turns (phase_turns_r),
    .out_valid   (chain_valid[0]),
    .out_ready   (chain_ready[0]),
    .out_item    (chain_item[0])
  );

  // row of horner cells, innermost series term first; each cell hands the
  // running term to its neighbor together with x, x squared and the quadrant
  for (genvar g = 0; g < HORNER_CELLS; g++) begin : g_horner
    swg_horner_cell #(
      .DIVISOR (horner_divisor(g))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_item   (chain_item[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_item  (chain_item[g+1])
    );
  end

  // back end: sine product, sign, amplitude, offset, saturation, output register
  swg_scale #(
    .SINE_BITS (SINE_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (chain_valid[HORNER_CELLS]),
    .in_ready   (chain_ready[HORNER_CELLS]),
    .in_item    (chain_item[HORNER_CELLS]),
    .amplitude  (amplitude_r),
    .offset     (offset_r),
    .out_valid  (out_valid),
    .out_ready  (!out_stall),
    .wave_value (wave_value),
    .active     (out_active)
  );

  assign out_wave_value = $signed(wave_value);

  // reset leaves no result pending
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // with the output register empty the whole pipeline can move
  assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> !in_stall)
    else $error("input stalled although the pipeline can drain");

  // a stalled result stays put until it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid && out_stall |=>
                   out_valid && $stable(out_wave_value) && $stable(out_active))
    else $error("stalled result changed or vanished");

endmodule

`default_nettype wire
